/* rtl/core/assert_macros.svh */
// Assertion macros shared by the flat JSON pair parser RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define FJP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low
`define FJP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/fjp_pkg.sv */
// Package for the flat JSON pair parser: character codes, phase, role and
// verdict types, and the step result struct. No dependencies.
package fjp_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned PAIRS_W     = 16;
  localparam int unsigned COUNT_W_DEF = 16;

  // Token characters
  localparam logic [BYTE_W-1:0] CHAR_LBRACE = 8'h7B;
  localparam logic [BYTE_W-1:0] CHAR_RBRACE = 8'h7D;
  localparam logic [BYTE_W-1:0] CHAR_COLON  = 8'h3A;
  localparam logic [BYTE_W-1:0] CHAR_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CHAR_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CHAR_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0D;

  // Parser phase, one-hot
  typedef enum logic [9:0] {
    PH_OPEN     = 10'b00_0000_0001,
    PH_FIRST    = 10'b00_0000_0010,
    PH_KEY      = 10'b00_0000_0100,
    PH_COLON    = 10'b00_0000_1000,
    PH_VALQ     = 10'b00_0001_0000,
    PH_VAL      = 10'b00_0010_0000,
    PH_SEP      = 10'b00_0100_0000,
    PH_KEYQ     = 10'b00_1000_0000,
    PH_ACCEPTED = 10'b01_0000_0000,
    PH_REJECTED = 10'b10_0000_0000
  } phase_e;

  typedef enum logic [2:0] {
    ROLE_STRUCT  = 3'd0,
    ROLE_KEY     = 3'd1,
    ROLE_VAL     = 3'd2,
    ROLE_KEYEND  = 3'd3,
    ROLE_VALEND  = 3'd4,
    ROLE_IGNORED = 3'd5
  } role_e;

  typedef enum logic [1:0] {
    VERD_RUNNING  = 2'd0,
    VERD_ACCEPTED = 2'd1,
    VERD_REJECTED = 2'd2
  } verdict_e;

  // Outcome of one byte against the current phase
  typedef struct packed {
    phase_e   next_phase;
    role_e    role;
    verdict_e verdict;
    logic     pair_inc;
  } step_t;

endpackage

/* rtl/core/flat_json_pair_parser.sv */
// Flat JSON pair parser: takes one byte per cycle and sustains one byte per
// cycle while the output is not stalled, each byte registered at input and output.
// A byte is captured in an input register, then the phase register and pair
// counter are updated in the same cycle that its result is loaded into the
// output register; this single phase loop is what bounds throughput. Each
// result carries the byte, its role, the pair count so far and the verdict,
// and tlast marks the result of the last byte; after it the parser is back in
// its reset state for the next value. No clearing pass after reset.
// Depends on fjp_pkg, fjp_step, fjp_pair_count and assert_macros.svh.
`include "assert_macros.svh"

module flat_json_pair_parser import fjp_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_W_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] echo_byte, [23:8] pairs_done,
                                      // [25:24] verdict, [31:26] zero
  output logic [2:0]  m_axis_tuser,   // [2:0] byte_role
  output logic        m_axis_tlast    // final_res
);

  logic               in_valid_q;
  logic [BYTE_W-1:0]  in_byte_q;
  logic               in_last_q;
  phase_e             phase_q, phase_d;

  logic               out_valid_q;
  logic [BYTE_W-1:0]  out_byte_q;
  role_e              out_role_q;
  logic [PAIRS_W-1:0] out_pairs_q;
  verdict_e           out_verdict_q;
  logic               out_last_q;

  logic               out_take;
  logic               advance;
  step_t              step;
  logic [PAIRS_W-1:0] pairs_done;

  // Handshake: output register frees when empty or drained
  assign out_take      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_take;
  assign s_axis_tready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  fjp_step u_step (
    .phase_i (phase_q),
    .byte_i  (in_byte_q),
    .last_i  (in_last_q),
    .step_o  (step)
  );

  fjp_pair_count #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_pair_count (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .pair_inc_i   (step.pair_inc),
    .clear_i      (in_last_q),
    .pairs_done_o (pairs_done)
  );

  // Phase register, back to the start after the last byte
  assign phase_d = in_last_q ? PH_OPEN : step.next_phase;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OPEN;
    end else if (advance) begin
      phase_q <= phase_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_take) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q    <= in_byte_q;
      out_role_q    <= step.role;
      out_pairs_q   <= pairs_done;
      out_verdict_q <= step.verdict;
      out_last_q    <= in_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_verdict_q, out_pairs_q, out_byte_q};
  assign m_axis_tuser  = out_role_q;
  assign m_axis_tlast  = out_last_q;

  `FJP_ASSERT_NXT(a_last_resets_phase, advance && in_last_q, phase_q == PH_OPEN,
                  "phase not reset after last byte")
  `FJP_ASSERT_IMP(a_accept_role, out_valid_q && (out_verdict_q == VERD_ACCEPTED),
                  (out_role_q == ROLE_STRUCT) || (out_role_q == ROLE_IGNORED),
                  "accepted result carries a key or value role")
  `FJP_ASSERT_IMP(a_valend_counts, out_valid_q && (out_role_q == ROLE_VALEND),
                  out_pairs_q != '0, "value end with zero pair count")

endmodule

/* rtl/core/fjp_step.sv */
// Per-byte transition logic of the flat JSON pair parser.
// Depends on fjp_pkg.
module fjp_step import fjp_pkg::*; (
  input  phase_e            phase_i,
  input  logic [BYTE_W-1:0] byte_i,
  input  logic              last_i,
  output step_t             step_o
);

  logic   is_space;
  phase_e next;
  role_e  role;
  logic   pair_inc;

  assign is_space = (byte_i == CHAR_SPACE) || (byte_i == CHAR_TAB) ||
                    (byte_i == CHAR_LF) || (byte_i == CHAR_CR);

  // Phase transition and role
  always_comb begin
    next     = phase_i;
    role     = ROLE_STRUCT;
    pair_inc = 1'b0;
    unique case (phase_i)
      PH_OPEN: begin
        if (byte_i == CHAR_LBRACE) next = PH_FIRST;
        else if (!is_space)        next = PH_REJECTED;
      end
      PH_FIRST: begin
        if (byte_i == CHAR_RBRACE)     next = PH_ACCEPTED;
        else if (byte_i == CHAR_QUOTE) next = PH_KEY;
        else if (!is_space)            next = PH_REJECTED;
      end
      PH_KEY: begin
        if (byte_i == CHAR_QUOTE) begin
          role = ROLE_KEYEND;
          next = PH_COLON;
        end else begin
          role = ROLE_KEY;
        end
      end
      PH_COLON: begin
        if (byte_i == CHAR_COLON) next = PH_VALQ;
        else if (!is_space)       next = PH_REJECTED;
      end
      PH_VALQ: begin
        if (byte_i == CHAR_QUOTE) next = PH_VAL;
        else if (!is_space)       next = PH_REJECTED;
      end
      PH_VAL: begin
        if (byte_i == CHAR_QUOTE) begin
          role     = ROLE_VALEND;
          next     = PH_SEP;
          pair_inc = 1'b1;
        end else begin
          role = ROLE_VAL;
        end
      end
      PH_SEP: begin
        if (byte_i == CHAR_COMMA)       next = PH_KEYQ;
        else if (byte_i == CHAR_RBRACE) next = PH_ACCEPTED;
        else if (!is_space)             next = PH_REJECTED;
      end
      PH_KEYQ: begin
        if (byte_i == CHAR_QUOTE) next = PH_KEY;
        else if (!is_space)       next = PH_REJECTED;
      end
      PH_ACCEPTED: begin
        role = ROLE_IGNORED;
      end
      default: begin
        role = ROLE_IGNORED;
        next = PH_REJECTED;
      end
    endcase
  end

  // A rejecting byte is itself ignored; the last byte settles the verdict
  always_comb begin
    step_o.next_phase = next;
    step_o.pair_inc   = pair_inc;
    step_o.role       = (next == PH_REJECTED) ? ROLE_IGNORED : role;
    if (next == PH_ACCEPTED)                  step_o.verdict = VERD_ACCEPTED;
    else if (next == PH_REJECTED || last_i)   step_o.verdict = VERD_REJECTED;
    else                                      step_o.verdict = VERD_RUNNING;
  end

endmodule

/* rtl/core/fjp_pair_count.sv */
// Saturating pair counter of the flat JSON pair parser, with the clipped
// 16-bit view. Depends on fjp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fjp_pair_count import fjp_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_W_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  logic               pair_inc_i,
  input  logic               clear_i,
  output logic [PAIRS_W-1:0] pairs_done_o
);

  logic [COUNT_WIDTH-1:0] count_q, count_d, count_new;

  // Count including the current byte, held at all ones
  assign count_new = (pair_inc_i && (count_q != '1)) ? count_q + 1'b1 : count_q;
  assign count_d   = clear_i ? '0 : count_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (advance_i) begin
      count_q <= count_d;
    end
  end

  // Reported value clips at the width of the result field
  if (COUNT_WIDTH > PAIRS_W) begin : g_clip
    assign pairs_done_o = (|count_new[COUNT_WIDTH-1:PAIRS_W]) ? '1
                                                               : count_new[PAIRS_W-1:0];
  end else begin : g_ext
    assign pairs_done_o = PAIRS_W'(count_new);
  end

  `FJP_ASSERT_NXT(a_clear_zero, advance_i && clear_i, count_q == '0,
                  "pair count not cleared after last byte")

endmodule
